FILE: rtl/core/source_text_tokenizer_defines.svh
// assertion macros for the source text tokenizer
// used by stt_lexer and stt_fifo; expects clk and rst_n in scope
`ifndef SOURCE_TEXT_TOKENIZER_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_DEFINES_SVH

// same-cycle implication
`define STT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define STT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/stt_pkg.sv
// shared types and constants of the source text tokenizer
// no dependencies
package stt_pkg;

    localparam int MAX_TOKEN_LEN = 63;
    localparam int LEN_W         = 6;
    localparam int PREFIX_DEPTH  = 5;
    localparam int QUEUE_DEPTH   = 4;

    // token kinds
    localparam logic [2:0] K_IDENT   = 3'd0;
    localparam logic [2:0] K_NUMBER  = 3'd1;
    localparam logic [2:0] K_KEYWORD = 3'd2;
    localparam logic [2:0] K_SYMBOL  = 3'd3;
    localparam logic [2:0] K_NEWLINE = 3'd4;
    localparam logic [2:0] K_END     = 3'd5;
    localparam logic [2:0] K_UNKNOWN = 3'd6;

    // keyword codes
    localparam logic [2:0] KW_NONE  = 3'd0;
    localparam logic [2:0] KW_INT   = 3'd1;
    localparam logic [2:0] KW_IF    = 3'd2;
    localparam logic [2:0] KW_WHILE = 3'd3;
    localparam logic [2:0] KW_PRINT = 3'd4;
    localparam logic [2:0] KW_AND   = 3'd5;
    localparam logic [2:0] KW_OR    = 3'd6;

    typedef struct packed {
        logic [2:0]       token_kind;
        logic [2:0]       keyword_code;
        logic [7:0]       first_char;
        logic [7:0]       second_char;
        logic [LEN_W-1:0] token_length;
        logic             overlong;
        logic [15:0]      start_position;
        logic             last;
    } tok_rec_t;

    // records produced by one byte, in output order a then b
    typedef struct packed {
        logic     a_valid;
        logic     b_valid;
        tok_rec_t a;
        tok_rec_t b;
    } tok_pair_t;

endpackage

FILE: rtl/core/stt_if.sv
// channel interfaces of the source text tokenizer
// depends on stt_pkg
interface stt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;

    modport source (output valid, output char_byte, input ready);
    modport sink (input valid, input char_byte, output ready);
endinterface

interface stt_token_if
    import stt_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [2:0]       token_kind;
    logic [2:0]       keyword_code;
    logic [7:0]       first_char;
    logic [7:0]       second_char;
    logic [LEN_W-1:0] token_length;
    logic             overlong;
    logic [15:0]      start_position;
    logic             last;

    modport source (output valid, output token_kind, output keyword_code,
                    output first_char, output second_char, output token_length,
                    output overlong, output start_position, output last,
                    input ready);
    modport sink (input valid, input token_kind, input keyword_code,
                  input first_char, input second_char, input token_length,
                  input overlong, input start_position, input last,
                  output ready);
endinterface

FILE: rtl/core/stt_lexer.sv
// lexer state and per-byte record decode
// depends on stt_pkg and source_text_tokenizer_defines.svh
`include "source_text_tokenizer_defines.svh"

module stt_lexer
    import stt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] char_byte,
    output tok_pair_t  recs
);

    typedef enum logic [1:0] {
        CLS_NONE = 2'd0,
        CLS_WORD = 2'd1,
        CLS_NUM  = 2'd2,
        CLS_EQ   = 2'd3
    } cls_t;

    cls_t             cls_reg, cls_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic             ovl_reg, ovl_next;
    logic [7:0]       prefix_reg [PREFIX_DEPTH];
    logic [7:0]       prefix_next [PREFIX_DEPTH];
    logic [15:0]      start_reg, start_next;
    logic [15:0]      pos_reg, pos_next;

    logic is_letter, is_digit, is_sym, is_blank;
    logic ext, eqeq, flush;
    logic [2:0] kw;

    assign is_letter = (char_byte >= "a" && char_byte <= "z")
                    || (char_byte >= "A" && char_byte <= "Z");
    assign is_digit  = char_byte >= "0" && char_byte <= "9";
    assign is_sym    = char_byte == ";" || char_byte == "{" || char_byte == "}"
                    || char_byte == "(" || char_byte == ")" || char_byte == "+"
                    || char_byte == "-" || char_byte == "<" || char_byte == ">";
    assign is_blank  = char_byte == " " || char_byte == 8'h09 || char_byte == 8'h0d;

    assign ext  = (cls_reg == CLS_WORD && (is_letter || is_digit))
               || (cls_reg == CLS_NUM && is_digit);
    assign eqeq = cls_reg == CLS_EQ && char_byte == "=";
    assign flush = !ext && !eqeq && cls_reg != CLS_NONE;

    // keyword lookup on the saved prefix
    always_comb
    begin
        kw = KW_NONE;
        if (!ovl_reg)
        begin
            if (len_reg == LEN_W'(3) && prefix_reg[0] == "i" && prefix_reg[1] == "n"
                && prefix_reg[2] == "t")
                kw = KW_INT;
            else if (len_reg == LEN_W'(2) && prefix_reg[0] == "i" && prefix_reg[1] == "f")
                kw = KW_IF;
            else if (len_reg == LEN_W'(5) && prefix_reg[0] == "w" && prefix_reg[1] == "h"
                && prefix_reg[2] == "i" && prefix_reg[3] == "l" && prefix_reg[4] == "e")
                kw = KW_WHILE;
            else if (len_reg == LEN_W'(5) && prefix_reg[0] == "p" && prefix_reg[1] == "r"
                && prefix_reg[2] == "i" && prefix_reg[3] == "n" && prefix_reg[4] == "t")
                kw = KW_PRINT;
            else if (len_reg == LEN_W'(3) && prefix_reg[0] == "a" && prefix_reg[1] == "n"
                && prefix_reg[2] == "d")
                kw = KW_AND;
            else if (len_reg == LEN_W'(2) && prefix_reg[0] == "o" && prefix_reg[1] == "r")
                kw = KW_OR;
        end
    end

    // records
    always_comb
    begin
        recs = '0;
        // record a: completed pending token or double equals
        recs.a_valid = flush || eqeq;
        recs.a.start_position = start_reg;
        if (eqeq)
        begin
            recs.a.token_kind   = K_SYMBOL;
            recs.a.first_char   = "=";
            recs.a.second_char  = "=";
            recs.a.token_length = LEN_W'(2);
        end
        else
        begin
            unique case (cls_reg)
                CLS_WORD: recs.a.token_kind = (kw != KW_NONE) ? K_KEYWORD : K_IDENT;
                CLS_NUM:  recs.a.token_kind = K_NUMBER;
                default:  recs.a.token_kind = K_SYMBOL;
            endcase
            recs.a.keyword_code = (cls_reg == CLS_WORD) ? kw : KW_NONE;
            recs.a.first_char   = prefix_reg[0];
            recs.a.token_length = len_reg;
            recs.a.overlong     = ovl_reg;
        end

        // record b: the byte's own one-character token
        recs.b_valid = !ext && !eqeq && !is_blank && !is_letter && !is_digit
                    && char_byte != "=";
        recs.b.start_position = pos_reg;
        recs.b.first_char     = char_byte;
        recs.b.token_length   = LEN_W'(1);
        recs.b.last           = 1'b1;
        if (char_byte == 8'h00)
        begin
            recs.b.token_kind   = K_END;
            recs.b.token_length = '0;
        end
        else if (char_byte == 8'h0a)
            recs.b.token_kind = K_NEWLINE;
        else if (is_sym)
            recs.b.token_kind = K_SYMBOL;
        else
            recs.b.token_kind = K_UNKNOWN;

        recs.a.last = !recs.b_valid;
    end

    // next state
    always_comb
    begin
        cls_next    = cls_reg;
        len_next    = len_reg;
        ovl_next    = ovl_reg;
        prefix_next = prefix_reg;
        start_next  = start_reg;
        pos_next    = pos_reg + 16'd1;
        if (ext)
        begin
            if (len_reg < LEN_W'(PREFIX_DEPTH))
                prefix_next[len_reg[2:0]] = char_byte;
            if (len_reg >= LEN_W'(MAX_TOKEN_LEN))
                ovl_next = 1'b1;
            else
                len_next = len_reg + LEN_W'(1);
        end
        else if (eqeq)
        begin
            cls_next = CLS_NONE;
            len_next = '0;
        end
        else
        begin
            cls_next = CLS_NONE;
            len_next = '0;
            ovl_next = 1'b0;
            if (char_byte == 8'h00)
            begin
                for (int i = 0; i < PREFIX_DEPTH; i++)
                    prefix_next[i] = '0;
                start_next = '0;
                pos_next   = '0;
            end
            else if (is_letter || is_digit || char_byte == "=")
            begin
                for (int i = 0; i < PREFIX_DEPTH; i++)
                    prefix_next[i] = '0;
                prefix_next[0] = char_byte;
                cls_next   = is_letter ? CLS_WORD : (is_digit ? CLS_NUM : CLS_EQ);
                len_next   = LEN_W'(1);
                start_next = pos_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cls_reg   <= CLS_NONE;
            len_reg   <= '0;
            ovl_reg   <= 1'b0;
            start_reg <= '0;
            pos_reg   <= '0;
            for (int i = 0; i < PREFIX_DEPTH; i++)
                prefix_reg[i] <= '0;
        end
        else if (accept)
        begin
            cls_reg    <= cls_next;
            len_reg    <= len_next;
            ovl_reg    <= ovl_next;
            start_reg  <= start_next;
            pos_reg    <= pos_next;
            prefix_reg <= prefix_next;
        end
    end

    `STT_ASSERT_NOW(a_eqeq_single, accept && eqeq, !recs.b_valid, "double equals gave two records")
    `STT_ASSERT_NEXT(a_end_rewind, accept && char_byte == 8'h00, pos_reg == '0 && cls_reg == CLS_NONE,
        "end of text did not return to idle")
    `STT_ASSERT_NOW(a_ovl_len, ovl_reg, len_reg == LEN_W'(MAX_TOKEN_LEN),
        "overlong flag without saturated length")

endmodule

FILE: rtl/core/stt_fifo.sv
// four-entry record queue, up to two pushes and one pop per cycle
// depends on stt_pkg and source_text_tokenizer_defines.svh
`include "source_text_tokenizer_defines.svh"

module stt_fifo
    import stt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  tok_pair_t recs,
    input  logic      push,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output tok_rec_t  out_rec
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tok_rec_t         mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push_a, push_b, pop;
    logic [PTR_W-1:0] idx_b;

    assign push_a    = push && recs.a_valid;
    assign push_b    = push && recs.b_valid;
    assign pop       = out_valid && out_ready;
    assign idx_b     = wr_ptr_reg + PTR_W'(push_a);
    // two free slots so a byte never stalls half-done
    assign room      = count_reg <= CNT_W'(QUEUE_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_rec   = mem[rd_ptr_reg];

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_a) + PTR_W'(push_b);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_a) + CNT_W'(push_b) - CNT_W'(pop);

    always_ff @(posedge clk)
    begin
        if (push_a)
            mem[wr_ptr_reg] <= recs.a;
        if (push_b)
            mem[idx_b] <= recs.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `STT_ASSERT_NOW(a_cnt_max, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `STT_ASSERT_NOW(a_push_room, push_a || push_b, room, "push without two free slots")
    `STT_ASSERT_NEXT(a_pop_only, pop && !push_a && !push_b,
        count_reg == $past(count_reg) - CNT_W'(1), "pop did not drop the count")

endmodule

FILE: rtl/core/source_text_tokenizer.sv
// a byte's records enter the queue at its accept edge; each is shown once the records ahead are taken
// throughput: one byte per cycle while each byte yields at most one record and the receiver is
// ready; a byte that closes a token and starts a one-character token yields two, which the single
// read port of the four-entry output queue drains at one per cycle, so input stalls while it holds over two
// reset: asynchronous, active low; clears lexer state, byte offset and the queue
// depends on stt_pkg, stt_if, stt_lexer, stt_fifo
module source_text_tokenizer
    import stt_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    stt_byte_if.sink          char_in,
    stt_token_if.source       token_out
);

    tok_pair_t recs;
    tok_rec_t  head;
    logic      room;
    logic      accept;

    // a byte is taken whenever the queue has room for both records it may make,
    // even while the head record is still waiting downstream
    assign char_in.ready = room;
    assign accept        = char_in.valid && room;

    // byte classification, pending-token state and record build
    stt_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_byte (char_in.char_byte),
        .recs      (recs)
    );

    // four-entry result queue: decouples the two sides and spreads
    // two-record bytes over two output beats
    stt_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .recs      (recs),
        .push      (accept),
        .room      (room),
        .out_valid (token_out.valid),
        .out_ready (token_out.ready),
        .out_rec   (head)
    );

    // unpack the head record onto the output beat
    assign token_out.token_kind     = head.token_kind;
    assign token_out.keyword_code   = head.keyword_code;
    assign token_out.first_char     = head.first_char;
    assign token_out.second_char    = head.second_char;
    assign token_out.token_length   = head.token_length;
    assign token_out.overlong       = head.overlong;
    assign token_out.start_position = head.start_position;
    assign token_out.last           = head.last;

endmodule

FILE: tb/sv/source_text_tokenizer_test.sv
// self-checking testbench of source_text_tokenizer: byte beats in, token records out
// holds its own model of the lexer and compares every token beat field by field
// depends on stt_pkg, stt_if and the source_text_tokenizer rtl
module source_text_tokenizer_test;
    import stt_pkg::*;

    // ascii characters the lexer treats specially
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EQ    = "=";

    localparam int RANDOM_ITEMS   = 200;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    // what the lexer is in the middle of
    typedef enum logic [1:0] {TOK_NONE, TOK_WORD, TOK_NUMBER, TOK_EQUALS} open_token_t;

    logic clk;
    logic rst_n;

    stt_byte_if  char_in ();
    stt_token_if token_out ();

    source_text_tokenizer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_in),
        .token_out (token_out)
    );

    // lexer model state
    open_token_t cur_class   = TOK_NONE;
    int unsigned cur_len     = 0;
    bit          cur_ovf     = 1'b0;
    logic [7:0]  cur_prefix [PREFIX_DEPTH] = '{default: 8'h00};
    logic [15:0] cur_start   = 16'h0000;
    logic [15:0] next_offset = 16'h0000;

    tok_rec_t    step_tokens [$];   // records of the byte being lexed
    tok_rec_t    due_tokens  [$];   // records still owed by the block, oldest first

    string       keyword_words [6] = '{"int", "if", "while", "print", "and", "or"};
    string       symbol_chars      = ";{}()+-<>";

    int          errors       = 0;
    int          bytes_sent   = 0;
    int          quiet_cycles = 0;
    int          rx_hold      = 0;
    bit          tx_gaps_on   = 1'b0;
    bit          rx_stalls_on = 1'b0;

    always #10 clk = ~clk;

    // ------------------------------------------------------------------
    // lexer model
    // ------------------------------------------------------------------

    function automatic bit is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR;
    endfunction

    // single-character symbols; '=' is handled apart since it may pair up
    function automatic bit is_symbol(logic [7:0] c);
        case (c)
            ";", "{", "}", "(", ")", "+", "-", "<", ">": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic tok_rec_t make_rec(logic [2:0] kind, logic [2:0] kw, logic [7:0] c1,
                                          logic [7:0] c2, int unsigned len, logic ovf,
                                          logic [15:0] pos);
        tok_rec_t r;
        r.token_kind     = kind;
        r.keyword_code   = kw;
        r.first_char     = c1;
        r.second_char    = c2;
        r.token_length   = LEN_W'(len);
        r.overlong       = ovf;
        r.start_position = pos;
        r.last           = 1'b0;
        return r;
    endfunction

    // only the first five characters are kept, so keywords are matched on those
    // together with the exact length; an overflowed word never matches
    function automatic bit word_is(string w);
        if (cur_ovf || cur_len != w.len() || w.len() > PREFIX_DEPTH)
            return 1'b0;
        for (int i = 0; i < w.len(); i++)
            if (cur_prefix[i] != w[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic logic [2:0] keyword_code_of();
        if (word_is("int"))   return KW_INT;
        if (word_is("if"))    return KW_IF;
        if (word_is("while")) return KW_WHILE;
        if (word_is("print")) return KW_PRINT;
        if (word_is("and"))   return KW_AND;
        if (word_is("or"))    return KW_OR;
        return KW_NONE;
    endfunction

    function automatic void start_token(open_token_t cls, logic [7:0] c);
        cur_prefix    = '{default: 8'h00};
        cur_prefix[0] = c;
        cur_class     = cls;
        cur_len       = 1;
        cur_ovf       = 1'b0;
        cur_start     = next_offset;
    endfunction

    // length saturates at the maximum and the overflow flag sticks
    function automatic void grow_token(logic [7:0] c);
        if (cur_len < PREFIX_DEPTH)
            cur_prefix[cur_len] = c;
        if (cur_len >= MAX_TOKEN_LEN)
            cur_ovf = 1'b1;
        else
            cur_len++;
    endfunction

    // emit whatever token is open and go back to nothing open
    function automatic void close_pending();
        logic [2:0] kw;
        case (cur_class)
            TOK_WORD:
            begin
                kw = keyword_code_of();
                step_tokens.push_back(make_rec(kw != KW_NONE ? K_KEYWORD : K_IDENT, kw,
                                               cur_prefix[0], 8'h00, cur_len, cur_ovf,
                                               cur_start));
            end
            TOK_NUMBER:
                step_tokens.push_back(make_rec(K_NUMBER, KW_NONE, cur_prefix[0], 8'h00,
                                               cur_len, cur_ovf, cur_start));
            TOK_EQUALS:
                step_tokens.push_back(make_rec(K_SYMBOL, KW_NONE, CH_EQ, 8'h00, 1, 1'b0,
                                               cur_start));
            default:
            begin
            end
        endcase
        cur_class = TOK_NONE;
        cur_len   = 0;
        cur_ovf   = 1'b0;
    endfunction

    // lex one accepted byte and queue the records it owes, last flag on the final one
    function automatic void lex_byte(logic [7:0] c);
        bit       taken;
        tok_rec_t rec;
        taken = 1'b0;
        step_tokens.delete();

        if (cur_class == TOK_WORD && (is_letter(c) || is_digit(c)))
        begin
            grow_token(c);
            taken = 1'b1;
        end
        else if (cur_class == TOK_NUMBER && is_digit(c))
        begin
            grow_token(c);
            taken = 1'b1;
        end
        else if (cur_class == TOK_EQUALS && c == CH_EQ)
        begin
            // double equals closes the open '=' and starts nothing new
            step_tokens.push_back(make_rec(K_SYMBOL, KW_NONE, CH_EQ, CH_EQ, 2, 1'b0,
                                           cur_start));
            cur_class = TOK_NONE;
            cur_len   = 0;
            taken     = 1'b1;
        end
        else
        begin
            close_pending();
        end

        // blanks only separate tokens
        if (!taken && !is_blank(c))
        begin
            if (c == CH_NUL)
            begin
                // end of text reports its own offset, then the block goes idle
                step_tokens.push_back(make_rec(K_END, KW_NONE, 8'h00, 8'h00, 0, 1'b0,
                                               next_offset));
                cur_prefix = '{default: 8'h00};
                cur_start  = 16'h0000;
            end
            else if (is_letter(c))
                start_token(TOK_WORD, c);
            else if (is_digit(c))
                start_token(TOK_NUMBER, c);
            else if (c == CH_EQ)
                start_token(TOK_EQUALS, c);
            else if (c == CH_NL)
                step_tokens.push_back(make_rec(K_NEWLINE, KW_NONE, c, 8'h00, 1, 1'b0,
                                               next_offset));
            else if (is_symbol(c))
                step_tokens.push_back(make_rec(K_SYMBOL, KW_NONE, c, 8'h00, 1, 1'b0,
                                               next_offset));
            else
                step_tokens.push_back(make_rec(K_UNKNOWN, KW_NONE, c, 8'h00, 1, 1'b0,
                                               next_offset));
        end

        next_offset = (c == CH_NUL) ? 16'h0000 : next_offset + 16'h0001;

        foreach (step_tokens[i])
        begin
            rec      = step_tokens[i];
            rec.last = (i == step_tokens.size() - 1);
            due_tokens.push_back(rec);
        end
    endfunction

    // ------------------------------------------------------------------
    // beat driving
    // ------------------------------------------------------------------

    // mostly back to back, often a short gap, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // called at a rising edge; returns at the edge that took the beat.
    // valid is only lowered when a gap is wanted, so back-to-back beats keep it high
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            char_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_in.valid     <= 1'b1;
        char_in.char_byte <= c;
        @(posedge clk);
        while (!char_in.ready)
            @(posedge clk);
        bytes_sent++;
        lex_byte(c);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // hold off the sender until every owed record is out, then let the block settle
    task automatic wait_drained();
        char_in.valid <= 1'b0;
        @(posedge clk);
        while (due_tokens.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver side: ready drops for random stretches while stalls are enabled
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            token_out.ready <= 1'b0;
            rx_hold         <= rx_hold - 1;
        end
        else
        begin
            token_out.ready <= 1'b1;
            if (rx_stalls_on)
                rx_hold <= pick_gap();
        end
    end

    // ------------------------------------------------------------------
    // token checking
    // ------------------------------------------------------------------

    task automatic check_field(input string field, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
        end
    endtask

    // values are sampled right at the edge, before anything clocked there updates
    always @(posedge clk)
    begin : check_tokens
        tok_rec_t want;
        if (rst_n && token_out.valid && token_out.ready)
        begin
            if (due_tokens.size() == 0)
            begin
                $display("%0t: token beat with nothing owed, actual kind %0h char %0h pos %0h",
                         $time, token_out.token_kind, token_out.first_char,
                         token_out.start_position);
                errors++;
            end
            else
            begin
                want = due_tokens.pop_front();
                check_field("token_kind", 16'(want.token_kind), 16'(token_out.token_kind));
                check_field("keyword_code", 16'(want.keyword_code),
                            16'(token_out.keyword_code));
                check_field("first_char", 16'(want.first_char), 16'(token_out.first_char));
                check_field("second_char", 16'(want.second_char),
                            16'(token_out.second_char));
                check_field("token_length", 16'(want.token_length),
                            16'(token_out.token_length));
                check_field("overlong", 16'(want.overlong), 16'(token_out.overlong));
                check_field("start_position", want.start_position, token_out.start_position);
                check_field("last", 16'(want.last), 16'(token_out.last));
            end
        end
    end

    // count cycles with no beat on either side
    always @(posedge clk)
    begin
        if ((char_in.valid && char_in.ready) || (token_out.valid && token_out.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("%0t: no beat for %0d cycles, %0d records still owed", $time,
                 WATCHDOG_LIMIT, due_tokens.size());
        $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every keyword, each closed by a different kind of byte
    task automatic test_keywords();
        send_text("int if\twhile\rprint(and;or\n");
    endtask

    // words that only look like keywords: case, extra or missing letters, trailing digit
    task automatic test_near_keywords();
        send_text("Int iff whil printer an o or1 ");
    endtask

    // numbers, every single symbol, a number closed by a letter
    task automatic test_symbols_and_numbers();
        send_text("x(0129)+{a-b}<c>d;12ab ");
    endtask

    // double equals, triple equals, separated singles, '=' closed by a symbol
    task automatic test_equals();
        send_text("a===b= =c==1=;");
    endtask

    // control, high and odd bytes, each its own unknown token, and a word closed by one of them
    task automatic test_unusual_bytes();
        send_byte(8'h80);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h01);
        send_text("_@ab");
        send_byte(8'hC3);
    endtask

    // end of text after an open word, number and '=', and with nothing open
    task automatic test_end_of_text();
        send_text("q");
        send_byte(CH_NUL);
        send_text("12");
        send_byte(CH_NUL);
        send_text("=");
        send_byte(CH_NUL);
        send_byte(CH_NUL);
    endtask

    task automatic send_word(input int len, input bit digits_only);
        for (int i = 0; i < len; i++)
        begin
            if (digits_only)
                send_byte(8'("0" + $urandom_range(0, 9)));
            else if (i == 0 || $urandom_range(0, 3) != 0)
                send_byte(8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25)
                                                  : "A" + $urandom_range(0, 25)));
            else
                send_byte(8'("0" + $urandom_range(0, 9)));
        end
    endtask

    // lengths just below, right at and past the saturation point
    task automatic test_overlong();
        send_word(MAX_TOKEN_LEN - 1, 1'b0);
        send_text(" ");
        send_word(MAX_TOKEN_LEN, 1'b0);
        send_text(";");
        send_word(MAX_TOKEN_LEN + 1, 1'b0);
        send_text(" ");
        send_word(MAX_TOKEN_LEN + 40, 1'b1);
        send_text("x");
        send_byte(CH_NUL);
    endtask

    // one token of program text, then maybe a separator
    task automatic send_random_token();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 18)
            send_text(keyword_words[$urandom_range(0, 5)]);
        else if (r < 42)
        begin
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
            send_word(len, 1'b0);
        end
        else if (r < 56)
        begin
            len = ($urandom_range(0, 39) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
            send_word(len, 1'b1);
        end
        else if (r < 76)
            send_byte(symbol_chars[$urandom_range(0, 8)]);
        else if (r < 84)
            send_byte(CH_EQ);
        else if (r < 92)
            send_text("==");
        else
            send_byte(CH_NL);

        // no separator lets tokens abut, which is where one byte gives two records
        r = $urandom_range(0, 15);
        if (r < 5)
            send_byte(CH_SPACE);
        else if (r == 5)
            send_byte(CH_TAB);
        else if (r == 6)
            send_byte(CH_CR);
        else if (r == 7)
            send_byte(CH_NUL);
    endtask

    // mostly well-formed text with random content, the rest raw bytes.
    // idling modes change every few dozen beats, and the sender pauses now and then
    task automatic test_random_text();
        int stop_at;
        int next_mode;
        int next_pause;
        stop_at    = bytes_sent + RANDOM_ITEMS;
        next_mode  = bytes_sent;
        next_pause = bytes_sent + 150;
        while (bytes_sent < stop_at)
        begin
            if (bytes_sent >= next_mode)
            begin
                tx_gaps_on   = $urandom_range(0, 3) != 0;
                rx_stalls_on = $urandom_range(0, 3) != 0;
                next_mode    = bytes_sent + 60;
            end
            if (bytes_sent >= next_pause)
            begin
                wait_drained();
                next_pause = bytes_sent + 150;
            end
            if ($urandom_range(0, 99) < 12)
                send_byte(($urandom_range(0, 19) == 0) ? CH_NUL : 8'($urandom_range(1, 255)));
            else
                send_random_token();
        end
    endtask

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        char_in.valid       = 1'b0;
        char_in.char_byte   = 8'h00;
        token_out.ready     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        test_keywords();
        test_near_keywords();
        test_symbols_and_numbers();
        test_equals();
        test_unusual_bytes();
        test_end_of_text();
        wait_drained();
        test_overlong();
        wait_drained();
        test_random_text();

        // drain with the receiver always ready so a stray record gets seen
        rx_stalls_on = 1'b0;
        wait_drained();
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
